// ----- sv/ntc_pkg.sv -----
// Shared types and constants of the thermistor sample to temperature converter.
`default_nettype none
package ntc_pkg;
    localparam int ADC_BITS = 16;
    localparam logic [15:0] FULL_SCALE = 16'((1 << ADC_BITS) - 1);

    localparam int DVD_W  = 49;
    localparam int DSR_W  = 38;
    localparam int STEP_W = 6;

    localparam logic [15:0]        LN2_Q16    = 16'd45426;
    localparam logic signed [38:0] INV_T0_Q32 = 39'sd14405391;
    localparam logic signed [27:0] ZERO_C_Q16 = 28'sd17901404;
    localparam logic [25:0]        TK_MAX     = 26'h3FF_FFFF;

    localparam logic [1:0] REG_BETA     = 2'd0;
    localparam logic [1:0] REG_TEMP_MIN = 2'd1;
    localparam logic [1:0] REG_TEMP_MAX = 2'd2;

    typedef struct packed {
        logic [15:0] raw;
        logic        invalid;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic signed [7:0] celsius;
        logic [8:0]        kelvin;
        logic              invalid;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_NORM,
        ST_SQ,
        ST_SQR,
        ST_LN,
        ST_DIV2,
        ST_DIV3,
        ST_CLAMP
    } t_state;
endpackage
`default_nettype wire

// ----- sv/thermistor_adc_to_celsius.sv -----
// Top level of the NTC thermistor sample to temperature converter.
//
//  channel   direction  handshake                beat
//  sample    in         push / full              raw_sample
//  result    out        pop / empty              celsius, kelvin, sample_invalid
//  config    in         i_cfg_valid/o_cfg_ready  index, data
//
// A valid sample holds the back end from the idle state through up to three
// runs of the shared one-bit-per-cycle divider, of 32, 37 and 49 steps (the
// last only if the denominator is positive), normalizing, the 16 squarings with
// a multiply and a renormalize state each, log scaling and clamp. An invalid
// sample skips the divider. Two samples queue ahead of the back end and two
// results behind it, so either side may stall without blocking the other.
// Reset is synchronous and restores beta 3950, clamps -40 and 125.
`default_nettype none
module thermistor_adc_to_celsius (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [15:0]        i_raw_sample,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [7:0]       o_celsius,
    output logic [8:0]              o_kelvin,
    output logic                    o_sample_invalid,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [13:0]        i_cfg_data
);
    import ntc_pkg::*;

    logic [13:0]       r_beta;
    logic signed [7:0] r_temp_min;
    logic signed [7:0] r_temp_max;
    logic              w_item_valid;
    t_item             w_item;
    logic              w_item_pop;
    t_result           w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta     <= 14'd3950;
            r_temp_min <= -8'sd40;
            r_temp_max <= 8'sd125;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BETA:     r_beta     <= i_cfg_data;
                REG_TEMP_MIN: r_temp_min <= i_cfg_data[7:0];
                REG_TEMP_MAX: r_temp_max <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ntc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_raw_sample (i_raw_sample),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    ntc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .i_beta       (r_beta),
        .i_temp_min   (r_temp_min),
        .i_temp_max   (r_temp_max),
        .empty        (empty),
        .pop          (pop),
        .o_result     (w_result)
    );

    assign o_celsius        = w_result.celsius;
    assign o_kelvin         = w_result.kelvin;
    assign o_sample_invalid = w_result.invalid;
endmodule
`default_nettype wire

// ----- sv/ntc_front.sv -----
// Front end: accepts samples, flags invalid ones and queues them for the back end.
`default_nettype none
module ntc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [15:0]   i_raw_sample,
    output logic               o_item_valid,
    output ntc_pkg::t_item     o_item,
    input  wire logic          i_item_pop
);
    import ntc_pkg::*;

    t_item      r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_push;
    logic       w_pop;
    t_item      w_new;

    assign full         = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rd];
    assign w_push       = push && !full;
    assign w_pop        = i_item_pop && o_item_valid;

    always_comb begin
        w_new.raw     = i_raw_sample;
        w_new.invalid = (i_raw_sample == 16'd0) || (i_raw_sample >= FULL_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_new;
    end
endmodule
`default_nettype wire

// ----- sv/ntc_div.sv -----
// Restoring divider, one quotient bit per cycle, dividend given left aligned.
`default_nettype none
module ntc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ntc_pkg::t_div_req           i_req,
    output logic                             o_done,
    output logic [ntc_pkg::DVD_W-1:0]        o_quotient
);
    import ntc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_acc;
    logic [DSR_W-1:0]  r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [DSR_W:0]    w_sh;
    logic              w_ge;
    logic [DSR_W:0]    w_diff;

    assign w_sh       = {r_rem, r_acc[DVD_W-1]};
    assign w_ge       = (w_sh >= {1'b0, r_dsr});
    assign w_diff     = w_sh - {1'b0, r_dsr};
    assign o_done     = r_done;
    assign o_quotient = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_cnt <= i_req.steps;
        end else if (r_busy) begin
            r_acc <= {r_acc[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DSR_W-1:0] : w_sh[DSR_W-1:0];
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end
endmodule
`default_nettype wire

// ----- sv/ntc_back.sv -----
// Back end: ratio, log, beta equation, clamp, and the result queue.
`default_nettype none
module ntc_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_item_valid,
    input  wire ntc_pkg::t_item        i_item,
    output logic                       o_item_pop,
    input  wire logic [13:0]           i_beta,
    input  wire logic signed [7:0]     i_temp_min,
    input  wire logic signed [7:0]     i_temp_max,
    output logic                       empty,
    input  wire logic                  pop,
    output ntc_pkg::t_result           o_result
);
    import ntc_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_m;
    logic [4:0]  r_p;
    logic [15:0] r_frac;
    logic [3:0]  r_bit;
    logic [61:0] r_prod;
    logic        r_neg;
    logic [25:0] r_tk;

    t_result     r_of [2];
    logic [1:0]  r_ocnt;
    logic        r_ord;
    logic        r_owr;

    t_div_req           w_req;
    logic               w_done;
    logic [DVD_W-1:0]   w_q;
    logic               w_wr;
    t_result            w_res;
    logic               w_start_ok;

    logic [15:0]        w_diff;
    logic signed [21:0] w_l2;
    logic               w_neg;
    logic [21:0]        w_mag;
    logic [36:0]        w_lnprod;
    logic [20:0]        w_lnmag;
    logic [13:0]        w_b;
    logic signed [38:0] w_d;
    logic [31:0]        w_t;
    logic signed [27:0] w_c;
    logic signed [27:0] w_lo;
    logic signed [27:0] w_hi;
    logic signed [11:0] w_trunc;
    logic signed [7:0]  w_cel;

    ntc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_done     (w_done),
        .o_quotient (w_q)
    );

    // Datapath values shared by the next-state and output logic.
    always_comb begin
        w_start_ok = i_item_valid && (r_ocnt != 2'd2);
        w_diff     = FULL_SCALE - i_item.raw;
        w_l2       = {6'({1'b0, r_p}) - 6'd16, r_frac};
        w_neg      = !r_p[4];
        w_mag      = w_neg ? 22'(-w_l2) : 22'(w_l2);
        w_lnprod   = 37'(w_mag[20:0]) * 37'(LN2_Q16) + 37'd32768;
        w_lnmag    = w_lnprod[36:16];
        w_b        = (i_beta == 14'd0) ? 14'd1 : i_beta;
        w_d        = r_neg ? INV_T0_Q32 - 39'(signed'({2'b0, w_q[36:0]}))
                           : INV_T0_Q32 + 39'(signed'({2'b0, w_q[36:0]}));
        w_t        = r_prod[61:30];
        w_c        = 28'(signed'({2'b0, r_tk})) - ZERO_C_Q16;
        w_lo       = 28'(i_temp_min) <<< 16;
        w_hi       = 28'(i_temp_max) <<< 16;
        w_trunc    = w_c[27:16] + 12'((w_c < 0) && (w_c[15:0] != 16'd0));
        if (w_c < w_lo) begin
            w_cel = i_temp_min;
        end else if (w_c > w_hi) begin
            w_cel = i_temp_max;
        end else begin
            w_cel = w_trunc[7:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start_ok && !i_item.invalid) n_state = ST_DIV1;
            end
            ST_DIV1: begin
                if (w_done) n_state = ST_NORM;
            end
            ST_NORM: begin
                if (r_m[31]) n_state = ST_SQ;
            end
            ST_SQ: n_state = ST_SQR;
            ST_SQR: begin
                n_state = (r_bit == 4'd15) ? ST_LN : ST_SQ;
            end
            ST_LN: n_state = ST_DIV2;
            ST_DIV2: begin
                if (w_done) n_state = (w_d <= 0) ? ST_CLAMP : ST_DIV3;
            end
            ST_DIV3: begin
                if (w_done) n_state = ST_CLAMP;
            end
            ST_CLAMP: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_req       = '0;
        o_item_pop  = 1'b0;
        w_wr        = 1'b0;
        w_res.celsius = w_cel;
        w_res.invalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_item_pop = w_start_ok;
                if (w_start_ok) begin
                    if (i_item.invalid) begin
                        w_wr          = 1'b1;
                        w_res.celsius = i_temp_min;
                        w_res.invalid = 1'b1;
                    end else begin
                        w_req.start    = 1'b1;
                        w_req.dividend = {w_diff, 33'd0};
                        w_req.divisor  = DSR_W'(i_item.raw);
                        w_req.steps    = STEP_W'(32);
                    end
                end
            end
            ST_LN: begin
                w_req.start    = 1'b1;
                w_req.dividend = {w_lnmag, 28'd0};
                w_req.divisor  = DSR_W'(w_b);
                w_req.steps    = STEP_W'(37);
            end
            ST_DIV2: begin
                if (w_done && w_d > 0) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = DVD_W'(1) << 48;
                    w_req.divisor  = w_d[DSR_W-1:0];
                    w_req.steps    = STEP_W'(49);
                end
            end
            ST_CLAMP: w_wr = 1'b1;
            default: ;
        endcase
        w_res.kelvin = 9'(signed'(w_res.celsius)) + 9'd273;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_DIV1: begin
                if (w_done) begin
                    r_m <= w_q[31:0];
                    r_p <= 5'd31;
                end
            end
            ST_NORM: begin
                // Top bit found: the mantissa is the normalized ratio moved down to Q1.30.
                if (r_m[31]) begin
                    r_m    <= r_m >> 1;
                    r_frac <= 16'd0;
                    r_bit  <= 4'd0;
                end else begin
                    r_m <= r_m << 1;
                    r_p <= r_p - 5'd1;
                end
            end
            ST_SQ: r_prod <= 62'(r_m[30:0]) * 62'(r_m[30:0]);
            ST_SQR: begin
                r_m    <= w_t[31] ? (w_t >> 1) : w_t;
                r_frac <= {r_frac[14:0], w_t[31]};
                r_bit  <= r_bit + 4'd1;
            end
            ST_LN: r_neg <= w_neg;
            ST_DIV2: begin
                if (w_done && w_d <= 0) r_tk <= TK_MAX;
            end
            ST_DIV3: begin
                if (w_done) begin
                    r_tk <= (w_q > DVD_W'(TK_MAX)) ? TK_MAX : w_q[25:0];
                end
            end
            default: ;
        endcase
    end

    // Two-entry result queue.
    assign empty    = (r_ocnt == 2'd0);
    assign o_result = r_of[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 2'd0;
            r_ord  <= 1'b0;
            r_owr  <= 1'b0;
        end else begin
            if (w_wr) r_owr <= ~r_owr;
            if (pop && !empty) r_ord <= ~r_ord;
            r_ocnt <= r_ocnt + 2'(w_wr) - 2'(pop && !empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_of[r_owr] <= w_res;
    end
endmodule
`default_nettype wire
